### hdl/ssr_pkg.sv
// Shared types, constants and helper functions for the streaming substring replace block.
// No dependencies; imported by every module of the block.
package ssr_pkg;

    // Size limits
    localparam int PATTERN_MAX = 8;
    localparam int REPLACE_MAX = 8;

    // Configuration register geometry (fixed by the register map)
    localparam int LEN_W     = 4;
    localparam int REG_W     = 64;
    localparam int REG_BYTES = REG_W / 8;
    localparam int NUM_REGS  = 4;
    localparam int IDX_W     = $clog2(NUM_REGS);
    localparam int ADDR_W    = $clog2(NUM_REGS * 8);

    // Register indexes
    localparam logic [IDX_W-1:0] REG_PATTERN_LEN   = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_PATTERN_BYTES = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_REPLACE_LEN   = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_REPLACE_BYTES = IDX_W'(3);

    // Count widths
    localparam int CNT_W  = $clog2(PATTERN_MAX + 1);
    localparam int RCNT_W = $clog2(REPLACE_MAX + 1);
    localparam int TAIL_W = (CNT_W > RCNT_W) ? CNT_W : RCNT_W;
    localparam int TOT_W  = $clog2(2 * PATTERN_MAX + REPLACE_MAX + 2);

    // Request queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int FPTR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_empty;
        logic       out_last;
    } out_item_t;

    typedef struct packed {
        logic [LEN_W-1:0] pattern_len;
        logic [REG_W-1:0] pattern_bytes;
        logic [LEN_W-1:0] replace_len;
        logic [REG_W-1:0] replace_bytes;
    } cfg_t;

    // One classified input item: what the back end has to emit for it
    typedef struct packed {
        logic [7:0]        raw_byte;   // incoming byte, emitted when it starts no match
        logic              emit_b;
        logic [CNT_W-1:0]  pre_cnt;    // released pattern bytes, from index 0
        logic              repl;       // tail is the replacement, else the flushed prefix
        logic [TAIL_W-1:0] tail_cnt;
        logic              last;
    } cmd_t;

    // Byte i of a 64-bit register; positions past the register read as zero
    function automatic logic [7:0] reg_byte(input logic [REG_W-1:0] r, input int unsigned i);
        logic [7:0] res;
        res = 8'h00;
        for (int j = 0; j < REG_BYTES; j++)
        begin
            if (i == j)
            begin
                res = r[8*j +: 8];
            end
        end
        return res;
    endfunction

    // Pattern length clamped to 1..PATTERN_MAX
    function automatic logic [CNT_W-1:0] eff_plen(input logic [LEN_W-1:0] l);
        logic [CNT_W-1:0] res;
        if (l == '0)
        begin
            res = CNT_W'(1);
        end
        else if (int'(l) > PATTERN_MAX)
        begin
            res = CNT_W'(PATTERN_MAX);
        end
        else
        begin
            res = CNT_W'(l);
        end
        return res;
    endfunction

    // Replacement length clamped to 0..REPLACE_MAX
    function automatic logic [TAIL_W-1:0] eff_rlen(input logic [LEN_W-1:0] l);
        logic [TAIL_W-1:0] res;
        if (int'(l) > REPLACE_MAX)
        begin
            res = TAIL_W'(REPLACE_MAX);
        end
        else
        begin
            res = TAIL_W'(l);
        end
        return res;
    endfunction

endpackage

### hdl/ssr_cfg.sv
// APB-style configuration registers for the substring replace block.
// Depends on ssr_pkg for the register map and the cfg_t struct.
module ssr_cfg
    import ssr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [REG_W-1:0]  pwdata,
    output logic [REG_W-1:0]  prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [LEN_W-1:0] pattern_len_reg;
    logic [REG_W-1:0] pattern_bytes_reg;
    logic [LEN_W-1:0] replace_len_reg;
    logic [REG_W-1:0] replace_bytes_reg;
    logic [IDX_W-1:0] idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1 -: IDX_W];
    assign wr_en  = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_len_reg   <= LEN_W'(1);
            pattern_bytes_reg <= '0;
            replace_len_reg   <= '0;
            replace_bytes_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_PATTERN_LEN:   pattern_len_reg   <= pwdata[LEN_W-1:0];
                REG_PATTERN_BYTES: pattern_bytes_reg <= pwdata;
                REG_REPLACE_LEN:   replace_len_reg   <= pwdata[LEN_W-1:0];
                REG_REPLACE_BYTES: replace_bytes_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (idx)
            REG_PATTERN_LEN:   prdata = REG_W'(pattern_len_reg);
            REG_PATTERN_BYTES: prdata = pattern_bytes_reg;
            REG_REPLACE_LEN:   prdata = REG_W'(replace_len_reg);
            REG_REPLACE_BYTES: prdata = replace_bytes_reg;
            default:           prdata = '0;
        endcase
    end

    assign cfg.pattern_len   = pattern_len_reg;
    assign cfg.pattern_bytes = pattern_bytes_reg;
    assign cfg.replace_len   = replace_len_reg;
    assign cfg.replace_bytes = replace_bytes_reg;

endmodule

### hdl/ssr_front.sv
// Front end: accepts input bytes, tracks the matched prefix length and
// classifies each byte into an emit request. Depends on ssr_pkg.
module ssr_front
    import ssr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     src_valid,
    output logic     src_stall,
    input  in_item_t src_item,
    input  logic     q_full,
    output logic     q_push,
    output cmd_t     q_cmd
);

    logic [CNT_W-1:0]       matched_reg;
    logic [CNT_W-1:0]       matched_next;
    logic [CNT_W-1:0]       plen;
    logic [TAIL_W-1:0]      rlen;
    logic [CNT_W-1:0]       m;
    logic [CNT_W-1:0]       n;
    logic [CNT_W-1:0]       s;
    logic [CNT_W-1:0]       nm;
    logic [PATTERN_MAX-1:0] ok;
    logic [TOT_W-1:0]       total;
    logic                   accept;

    assign plen      = eff_plen(cfg.pattern_len);
    assign rlen      = eff_rlen(cfg.replace_len);
    assign src_stall = q_full;
    assign accept    = src_valid && !q_full;

    // Held prefix length, clipped below the current pattern length
    assign m = (matched_reg >= plen) ? plen - CNT_W'(1) : matched_reg;
    assign n = m + CNT_W'(1);

    // Each start s: does held[s..n-1] equal the pattern head
    always_comb
    begin
        for (int st = 0; st < PATTERN_MAX; st++)
        begin
            ok[st] = (st < int'(n));
            for (int i = 0; i < PATTERN_MAX; i++)
            begin
                if (st + i < int'(n))
                begin
                    if (st + i < int'(m))
                    begin
                        if (reg_byte(cfg.pattern_bytes, st + i) !=
                            reg_byte(cfg.pattern_bytes, i))
                        begin
                            ok[st] = 1'b0;
                        end
                    end
                    else if (src_item.in_byte != reg_byte(cfg.pattern_bytes, i))
                    begin
                        ok[st] = 1'b0;
                    end
                end
            end
        end
    end

    // Earliest surviving start; n when no start survives
    always_comb
    begin
        s = n;
        for (int st = PATTERN_MAX - 1; st >= 0; st--)
        begin
            if (ok[st])
            begin
                s = CNT_W'(st);
            end
        end
    end

    assign nm = n - s;

    // Build the emit request
    always_comb
    begin
        q_cmd.raw_byte = src_item.in_byte;
        q_cmd.emit_b   = (s == n);
        q_cmd.pre_cnt  = (s == n) ? m : s;
        q_cmd.repl     = (nm == plen);
        q_cmd.last     = src_item.in_last;
        if (nm == plen)
        begin
            q_cmd.tail_cnt = rlen;
        end
        else if (src_item.in_last)
        begin
            q_cmd.tail_cnt = TAIL_W'(nm);
        end
        else
        begin
            q_cmd.tail_cnt = '0;
        end
    end

    assign total = TOT_W'(q_cmd.pre_cnt) + TOT_W'(q_cmd.emit_b) + TOT_W'(q_cmd.tail_cnt);

    // Requests that release nothing and do not end the string are dropped here
    assign q_push       = accept && ((total != '0) || src_item.in_last);
    assign matched_next = (q_cmd.repl || src_item.in_last) ? '0 : nm;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matched_reg <= '0;
        end
        else if (accept)
        begin
            matched_reg <= matched_next;
        end
    end

    a_clear_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (q_cmd.repl || src_item.in_last) |=> matched_reg == '0)
        else $error("matched count not cleared after replacement or end of string");

    a_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("request pushed into full queue");

endmodule

### hdl/ssr_fifo.sv
// Short request queue between the front and back ends.
// Depends on ssr_pkg for cmd_t and the queue depth.
module ssr_fifo
    import ssr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t wr_cmd,
    input  logic pop,
    output cmd_t rd_cmd,
    output logic full,
    output logic empty
);

    cmd_t              mem [FIFO_DEPTH];
    logic [FPTR_W-1:0] wr_ptr_reg;
    logic [FPTR_W-1:0] rd_ptr_reg;
    logic [FCNT_W-1:0] count_reg;

    assign full   = (count_reg == FCNT_W'(FIFO_DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_cmd = mem[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (int'(wr_ptr_reg) == FIFO_DEPTH - 1) ? '0 : wr_ptr_reg + FPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (int'(rd_ptr_reg) == FIFO_DEPTH - 1) ? '0 : rd_ptr_reg + FPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + FCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - FCNT_W'(1);
            end
        end
    end

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

endmodule

### hdl/ssr_back.sv
// Back end: walks one emit request at a time and, unless stalled, drives one
// result byte per cycle into the output register. Depends on ssr_pkg.
module ssr_back
    import ssr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  cmd_t      head,
    input  logic      q_empty,
    output logic      q_pop,
    output logic      dst_valid,
    input  logic      dst_stall,
    output out_item_t dst_item
);

    logic [TOT_W-1:0] k_reg;
    logic [TOT_W-1:0] k_next;
    logic [TOT_W-1:0] total;
    logic [TOT_W-1:0] j;
    logic             is_final;
    logic             load;
    logic             out_valid_reg;
    out_item_t        out_reg;
    out_item_t        out_next;

    assign total    = TOT_W'(head.pre_cnt) + TOT_W'(head.emit_b) + TOT_W'(head.tail_cnt);
    assign is_final = (total == '0) || (k_reg == total - TOT_W'(1));
    assign load     = !q_empty && (!out_valid_reg || !dst_stall);
    assign q_pop    = load && is_final;
    assign k_next   = is_final ? '0 : k_reg + TOT_W'(1);
    assign j        = k_reg - TOT_W'(head.pre_cnt) - TOT_W'(head.emit_b);

    // Pick result byte k of the current request
    always_comb
    begin
        out_next.out_empty = 1'b0;
        out_next.out_last  = head.last && is_final;
        if (total == '0)
        begin
            out_next.out_byte  = 8'h00;
            out_next.out_empty = 1'b1;
        end
        else if (k_reg < TOT_W'(head.pre_cnt))
        begin
            out_next.out_byte = reg_byte(cfg.pattern_bytes, int'(k_reg));
        end
        else if (head.emit_b && (k_reg == TOT_W'(head.pre_cnt)))
        begin
            out_next.out_byte = head.raw_byte;
        end
        else if (head.repl)
        begin
            out_next.out_byte = reg_byte(cfg.replace_bytes, int'(j));
        end
        else
        begin
            out_next.out_byte = reg_byte(cfg.pattern_bytes, int'(j));
        end
    end

    // Sequencer position and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            k_reg         <= k_next;
            out_valid_reg <= 1'b1;
        end
        else if (!dst_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= out_next;
        end
    end

    assign dst_valid = out_valid_reg;
    assign dst_item  = out_reg;

    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> (k_reg < total) || (total == '0 && k_reg == '0))
        else $error("sequencer position past end of request");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_item.out_empty |-> dst_item.out_last && dst_item.out_byte == 8'h00)
        else $error("end marker without last flag or with data");

endmodule

### hdl/stream_substring_replace_top.sv
// Top level of the streaming substring replace block.
// Depends on ssr_pkg, ssr_cfg, ssr_front, ssr_fifo and ssr_back.
//
// Replaces every non-overlapping occurrence of a pattern (1 to 8 bytes) in a
// byte stream with a replacement (0 to 8 bytes), scanning left to right and
// re-scanning the held prefix on a mismatch so occurrences that start inside a
// partial match are found. The front end takes one input byte per cycle, unless
// the two-entry request queue is full; the back end sequencer emits one result
// byte per cycle while the queue holds a request and the output is not stalled.
// Each input byte releases between 0 and 8 results (a string's final byte
// always yields at least one result, an empty end marker when nothing else is
// released). Bytes that release nothing are dropped by the front end. There
// is no clearing pass after reset. Configuration registers are 64 bits wide
// at byte addresses 0, 8, 16, 24 (pattern_len, pattern_bytes, replace_len,
// replace_bytes) and must only be written while the block is idle.
module stream_substring_replace_top
    import ssr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [REG_W-1:0]  pwdata,
    output logic [REG_W-1:0]  prdata,
    output logic              pready,
    input  logic              src_valid,
    output logic              src_stall,
    input  in_item_t          src_item,
    output logic              dst_valid,
    input  logic              dst_stall,
    output out_item_t         dst_item
);

    cfg_t cfg;
    cmd_t push_cmd;
    cmd_t head_cmd;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;

    // Configuration registers
    ssr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Match tracking and classification
    ssr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    // Request queue
    ssr_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wr_cmd (push_cmd),
        .pop    (q_pop),
        .rd_cmd (head_cmd),
        .full   (q_full),
        .empty  (q_empty)
    );

    // Result sequencer
    ssr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .head      (head_cmd),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_item  (dst_item)
    );

endmodule
